@@ design/brf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants for the byte ring FIFO.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int DEPTH = 256;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CAP_W = PTR_W + 1;
    localparam int BYTE_W = 8;
    localparam int SKIP_W = 16;

    localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(2);
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_SKIP  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

endpackage

@@ design/brf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_req_if / brf_rsp_if
// Valid/ready channels for FIFO operation words and their result words.
// ----------------------------------------------------------------------------
interface brf_req_if
    import brf_pkg::*;
;
    logic              valid;
    logic              ready;
    op_t               op;
    logic [BYTE_W-1:0] write_data;
    logic [SKIP_W-1:0] skip_count;

    modport source (output valid, output op, output write_data, output skip_count,
                    input ready);
    modport sink   (input valid, input op, input write_data, input skip_count,
                    output ready);
endinterface

interface brf_rsp_if
    import brf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic              done_res;
    logic [BYTE_W-1:0] skipped;
    logic [BYTE_W-1:0] level;
    logic [BYTE_W-1:0] space;

    modport source (output valid, output read_data, output done_res, output skipped,
                    output level, output space, input ready);
    modport sink   (input valid, input read_data, input done_res, input skipped,
                    input level, input space, output ready);
endinterface

@@ design/byte_ring_fifo_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_core
// Byte ring FIFO with one empty slot, programmable capacity, push, pop,
// skip and clear operations, one result word per operation word.
// ----------------------------------------------------------------------------
// On acceptance of an operation word the pointers and the fill level update
// and the store access is issued, with the word held in stage one; the
// output register captures the store's registered read data when stage one
// advances, and the result sits there until taken. A new word
// is accepted every cycle as long as result words are drained; the single
// port of the byte store (one write or one read per word) sets that figure.
// The capacity register (2..256, out-of-range values clamp) clears both
// pointers when written; write it only while the FIFO is idle and follow it
// with a clear as usual. The byte store has no reset and needs no clearing.
// ----------------------------------------------------------------------------
module byte_ring_fifo_core
    import brf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    brf_req_if.sink          req,
    brf_rsp_if.source        rsp
);

    // Byte store, synchronous read.
    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] mem_q_reg;

    // Pointer and level state.
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  level_reg, level_next;

    // Stage one: waits for the store read data.
    logic              s1_valid_reg;
    logic              s1_rd_reg;
    logic              s1_done_reg;
    logic [BYTE_W-1:0] s1_skipped_reg;
    logic [BYTE_W-1:0] s1_level_reg;
    logic [BYTE_W-1:0] s1_space_reg;

    // Output register.
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_rdata_reg;
    logic              out_done_reg;
    logic [BYTE_W-1:0] out_skipped_reg;
    logic [BYTE_W-1:0] out_level_reg;
    logic [BYTE_W-1:0] out_space_reg;

    logic              acc;
    logic              s1_adv;
    logic              can_wr;
    logic              can_rd;
    logic [PTR_W-1:0]  skip_n;
    logic [CAP_W-1:0]  wp_inc;
    logic [CAP_W-1:0]  rp_sum;
    logic [PTR_W-1:0]  rp_step;
    logic              mem_we;
    logic              mem_re;
    logic              done_c;
    logic [PTR_W-1:0]  skipped_c;
    logic [CAP_W-1:0]  space_c;

    // Handshake: stage one drains into the output register when it is free.
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign acc       = req.valid && req.ready;

    // Full when level reaches capacity minus one; the one empty slot tells
    // full apart from empty.
    assign can_wr = ({1'b0, level_reg} != (cap_reg - CAP_W'(1)));
    assign can_rd = (level_reg != '0);

    // Clamp the skip request to the current level.
    assign skip_n = (req.skip_count > SKIP_W'(level_reg)) ? level_reg
                                                          : req.skip_count[PTR_W-1:0];

    // Advance pointers, wrap by a single compare and subtract.
    assign rp_step = (req.op == OP_READ) ? PTR_W'(1) : skip_n;
    assign wp_inc  = {1'b0, wp_reg} + CAP_W'(1);
    assign rp_sum  = {1'b0, rp_reg} + {1'b0, rp_step};

    // Operation decode.
    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        level_next = level_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        done_c     = 1'b0;
        skipped_c  = '0;
        unique case (req.op)
            OP_WRITE:
            begin
                if (can_wr)
                begin
                    mem_we     = 1'b1;
                    done_c     = 1'b1;
                    wp_next    = (wp_inc >= cap_reg) ? PTR_W'(wp_inc - cap_reg)
                                                     : wp_inc[PTR_W-1:0];
                    level_next = level_reg + PTR_W'(1);
                end
            end
            OP_READ:
            begin
                if (can_rd)
                begin
                    mem_re     = 1'b1;
                    done_c     = 1'b1;
                    rp_next    = (rp_sum >= cap_reg) ? PTR_W'(rp_sum - cap_reg)
                                                     : rp_sum[PTR_W-1:0];
                    level_next = level_reg - PTR_W'(1);
                end
            end
            OP_SKIP:
            begin
                skipped_c  = skip_n;
                rp_next    = (rp_sum >= cap_reg) ? PTR_W'(rp_sum - cap_reg)
                                                 : rp_sum[PTR_W-1:0];
                level_next = level_reg - skip_n;
            end
            OP_CLEAR:
            begin
                wp_next    = '0;
                rp_next    = '0;
                level_next = '0;
            end
            default:
            begin
                wp_next = wp_reg;
            end
        endcase
    end

    // Free space after the operation.
    assign space_c = cap_reg - {1'b0, level_next} - CAP_W'(1);

    // Clamp the capacity write into the usable range.
    always_comb
    begin
        if (cfg_wdata < CAP_MIN)
            cap_next = CAP_MIN;
        else if (cfg_wdata > CAP_MAX)
            cap_next = CAP_MAX;
        else
            cap_next = cfg_wdata;
    end

    // Control state: capacity, pointers, level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_MAX;
            wp_reg    <= '0;
            rp_reg    <= '0;
            level_reg <= '0;
        end
        else if (cfg_we)
        begin
            // Capacity change drops everything held.
            cap_reg   <= cap_next;
            wp_reg    <= '0;
            rp_reg    <= '0;
            level_reg <= '0;
        end
        else if (acc)
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            level_reg <= level_next;
        end
    end

    // Byte store: write at the write pointer, read at the read pointer.
    // Read data holds until the next accepted pop.
    always_ff @(posedge clk)
    begin
        if (acc && mem_we)
            mem[wp_reg] <= req.write_data;
        if (acc && mem_re)
            mem_q_reg <= mem[rp_reg];
    end

    // Stage one valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (acc)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    // Stage one payload.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_rd_reg      <= mem_re;
            s1_done_reg    <= done_c;
            s1_skipped_reg <= skipped_c;
            s1_level_reg   <= level_next;
            s1_space_reg   <= space_c[BYTE_W-1:0];
        end
    end

    // Output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload; a word that popped nothing reports zero data.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_rdata_reg   <= s1_rd_reg ? mem_q_reg : '0;
            out_done_reg    <= s1_done_reg;
            out_skipped_reg <= s1_skipped_reg;
            out_level_reg   <= s1_level_reg;
            out_space_reg   <= s1_space_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_rdata_reg;
    assign rsp.done_res  = out_done_reg;
    assign rsp.skipped   = out_skipped_reg;
    assign rsp.level     = out_level_reg;
    assign rsp.space     = out_space_reg;

    // Pointers stay inside the slots in use.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, wp_reg} < cap_reg) && ({1'b0, rp_reg} < cap_reg))
        else $error("pointer beyond capacity");

    // Tracked level never reaches the capacity.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, level_reg} < cap_reg)
        else $error("level beyond capacity minus one");

    // Tracked level agrees with the pointer distance.
    a_level_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg >= rp_reg) ? (level_reg == PTR_W'(wp_reg - rp_reg))
                           : ({1'b0, level_reg} ==
                              (cap_reg - {1'b0, rp_reg} + {1'b0, wp_reg})))
        else $error("level out of step with pointers");

    // A stalled stage one keeps its word.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("stage one word lost");

endmodule
